// ----- rtl/refcount_handle_table_assert.svh -----
// assertion macros for the handle table checker
`ifndef REFCOUNT_HANDLE_TABLE_ASSERT_SVH
`define REFCOUNT_HANDLE_TABLE_ASSERT_SVH

// same-cycle implication, off while reset is high
`define RHT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("handle table assertion failed");

// next-cycle implication, off while reset is high
`define RHT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("handle table assertion failed");

// next-cycle implication that also holds across reset
`define RHT_ASSERT_ALW(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("handle table assertion failed");

`endif

// ----- rtl/rht_pkg.sv -----
// types and constants of the reference-counting handle table
package rht_pkg;

   localparam int HANDLE_W    = 5;
   localparam int COUNT_W     = 8;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int MAX_RESULTS = 16;

   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [CMD_W-1:0]    cmd_bits_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_ASSIGN  = 2'd1,
      CMD_COLLECT = 2'd2
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_SAT  = 2'd2,
      STATUS_NONE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ALU_DEC,
      ALU_INC,
      ALU_ZERO
   } alu_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC,
      S_ASG_RD,
      S_ASG_OLD,
      S_ASG_NEW,
      S_COL_RD,
      S_COL_CHK,
      S_COL_END
   } state_type;

   typedef struct packed {
      count_type result;
      logic      flag;
   } alu_out_type;

   typedef struct packed {
      logic       valid;
      status_type status;
      handle_type handle;
      logic       last;
   } rsp_push_type;

endpackage

// ----- rtl/rht_if.sv -----
// request and response channel interfaces
interface rht_req_if;
   logic                  valid;
   logic                  ready;
   rht_pkg::cmd_bits_type command;
   rht_pkg::handle_type   old_handle;
   rht_pkg::handle_type   new_handle;

   modport source (output valid, command, old_handle, new_handle, input ready);
   modport sink (input valid, command, old_handle, new_handle, output ready);
endinterface

interface rht_rsp_if;
   logic                valid;
   logic                ready;
   rht_pkg::status_type status;
   rht_pkg::handle_type handle;
   logic                last;

   modport source (output valid, status, handle, last, input ready);
   modport sink (input valid, status, handle, last, output ready);
endinterface

// ----- rtl/rht_count_ram.sv -----
// reference count memory, one write and one registered read port
module rht_count_ram #(
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  rht_pkg::count_type                     wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output rht_pkg::count_type                     rd_data
);

   rht_pkg::count_type mem [DEPTH];
   rht_pkg::count_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rht_alu.sv -----
// shared count unit: decrement, increment and zero test with clamp flags
module rht_alu (
   input  rht_pkg::alu_op_type  op,
   input  rht_pkg::count_type   operand,
   output rht_pkg::alu_out_type res
);

   always_comb begin
      res.result = operand;
      res.flag   = 1'b0;
      case (op)
         rht_pkg::ALU_DEC: begin
            res.flag   = (operand == '0);
            res.result = operand - rht_pkg::COUNT_W'(1);
         end
         rht_pkg::ALU_INC: begin
            res.flag   = (operand == '1);
            res.result = operand + rht_pkg::COUNT_W'(1);
         end
         rht_pkg::ALU_ZERO: begin
            res.flag = (operand == '0);
         end
         default: begin
            res.flag = 1'b0;
         end
      endcase
   end

endmodule

// ----- rtl/rht_ctrl.sv -----
// command sequencer with slot valid bits and scan counters
module rht_ctrl #(
   parameter int SLOTS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   rht_req_if.sink                                req_bus,
   input  logic                                   space,
   output rht_pkg::rsp_push_type                  push,
   output rht_pkg::alu_op_type                    alu_op,
   input  rht_pkg::alu_out_type                   alu_res,
   output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
   output logic                                   wr_en,
   output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
   output rht_pkg::count_type                     wr_data
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int EXT_W  = (SLOT_W > rht_pkg::HANDLE_W) ? SLOT_W : rht_pkg::HANDLE_W;
   localparam int RES_W  = $clog2(rht_pkg::MAX_RESULTS + 1);

   rht_pkg::state_type  state_ff, state_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [RES_W-1:0]    n_ff, n_in;
   logic                pend_ff, pend_in;
   rht_pkg::handle_type pend_handle_ff, pend_handle_in;
   rht_pkg::handle_type old_h_ff, old_h_in;
   rht_pkg::handle_type new_h_ff, new_h_in;
   logic                sat_ff, sat_in;
   logic [SLOTS-1:0]    valid_ff, valid_in;

   logic [EXT_W-1:0]    old_m1, new_m1;
   logic [SLOT_W-1:0]   old_slot, new_slot;
   logic                old_ok, new_ok, same, old_act, new_act;
   logic                idx_last, cur_free, freeing, col_stall, accept;
   rht_pkg::handle_type idx_handle;

   // handle to slot, with range and valid checks
   assign old_m1   = EXT_W'(old_h_ff) - EXT_W'(1);
   assign new_m1   = EXT_W'(new_h_ff) - EXT_W'(1);
   assign old_slot = old_m1[SLOT_W-1:0];
   assign new_slot = new_m1[SLOT_W-1:0];
   assign old_ok   = (old_h_ff != '0) && (32'(old_h_ff) <= SLOTS) && valid_ff[old_slot];
   assign new_ok   = (new_h_ff != '0) && (32'(new_h_ff) <= SLOTS) && valid_ff[new_slot];
   assign same     = old_ok && (old_h_ff == new_h_ff);
   assign old_act  = old_ok && !same;
   assign new_act  = new_ok && !same;

   assign idx_last   = (idx_ff == SLOT_W'(SLOTS - 1));
   assign idx_handle = rht_pkg::handle_type'(32'(idx_ff) + 1);
   assign cur_free   = !valid_ff[idx_ff];
   assign freeing    = valid_ff[idx_ff] && alu_res.flag
                       && (n_ff < RES_W'(rht_pkg::MAX_RESULTS));
   // a second freed slot must wait until the held one can be sent
   assign col_stall  = freeing && pend_ff && !space;

   assign req_bus.ready = (state_ff == rht_pkg::S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rht_pkg::S_IDLE: begin
            if (accept) begin
               case (req_bus.command)
                  rht_pkg::CMD_ALLOC:   state_in = rht_pkg::S_ALLOC;
                  rht_pkg::CMD_ASSIGN:  state_in = rht_pkg::S_ASG_RD;
                  rht_pkg::CMD_COLLECT: state_in = rht_pkg::S_COL_RD;
                  default:              state_in = rht_pkg::S_IDLE;
               endcase
            end
         end
         rht_pkg::S_ALLOC: begin
            if ((cur_free || idx_last) && space) begin
               state_in = rht_pkg::S_IDLE;
            end
         end
         rht_pkg::S_ASG_RD:  state_in = rht_pkg::S_ASG_OLD;
         rht_pkg::S_ASG_OLD: state_in = rht_pkg::S_ASG_NEW;
         rht_pkg::S_ASG_NEW: begin
            if (space) begin
               state_in = rht_pkg::S_IDLE;
            end
         end
         rht_pkg::S_COL_RD: state_in = rht_pkg::S_COL_CHK;
         rht_pkg::S_COL_CHK: begin
            if (!col_stall) begin
               state_in = idx_last ? rht_pkg::S_COL_END : rht_pkg::S_COL_RD;
            end
         end
         rht_pkg::S_COL_END: begin
            if (space) begin
               state_in = rht_pkg::S_IDLE;
            end
         end
         default: state_in = rht_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      idx_in         = idx_ff;
      n_in           = n_ff;
      pend_in        = pend_ff;
      pend_handle_in = pend_handle_ff;
      old_h_in       = old_h_ff;
      new_h_in       = new_h_ff;
      sat_in         = sat_ff;
      valid_in       = valid_ff;
      push.valid     = 1'b0;
      push.status    = rht_pkg::STATUS_OK;
      push.handle    = '0;
      push.last      = 1'b0;
      alu_op         = rht_pkg::ALU_ZERO;
      rd_addr        = idx_ff;
      wr_en          = 1'b0;
      wr_addr        = idx_ff;
      wr_data        = alu_res.result;
      case (state_ff)
         rht_pkg::S_IDLE: begin
            if (accept) begin
               old_h_in = req_bus.old_handle;
               new_h_in = req_bus.new_handle;
               idx_in   = '0;
               n_in     = '0;
               pend_in  = 1'b0;
               sat_in   = 1'b0;
            end
         end
         rht_pkg::S_ALLOC: begin
            if (cur_free) begin
               if (space) begin
                  push.valid       = 1'b1;
                  push.handle      = idx_handle;
                  push.last        = 1'b1;
                  valid_in[idx_ff] = 1'b1;
                  wr_en            = 1'b1;
                  wr_data          = rht_pkg::COUNT_W'(1);
               end
            end else if (idx_last) begin
               if (space) begin
                  push.valid  = 1'b1;
                  push.status = rht_pkg::STATUS_FULL;
                  push.last   = 1'b1;
               end
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         rht_pkg::S_ASG_RD: begin
            rd_addr = old_slot;
         end
         rht_pkg::S_ASG_OLD: begin
            rd_addr = new_slot;
            alu_op  = rht_pkg::ALU_DEC;
            if (old_act) begin
               if (alu_res.flag) begin
                  sat_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = old_slot;
               end
            end
         end
         rht_pkg::S_ASG_NEW: begin
            rd_addr = new_slot;
            alu_op  = rht_pkg::ALU_INC;
            if (space) begin
               push.valid  = 1'b1;
               push.status = (sat_ff || (new_act && alu_res.flag))
                             ? rht_pkg::STATUS_SAT : rht_pkg::STATUS_OK;
               push.last   = 1'b1;
               if (new_act && !alu_res.flag) begin
                  wr_en   = 1'b1;
                  wr_addr = new_slot;
               end
            end
         end
         rht_pkg::S_COL_RD: begin
            rd_addr = idx_ff;
         end
         rht_pkg::S_COL_CHK: begin
            if (!col_stall) begin
               if (freeing) begin
                  valid_in[idx_ff] = 1'b0;
                  pend_in          = 1'b1;
                  pend_handle_in   = idx_handle;
                  n_in             = n_ff + RES_W'(1);
                  if (pend_ff) begin
                     push.valid  = 1'b1;
                     push.handle = pend_handle_ff;
                  end
               end
               if (!idx_last) begin
                  idx_in = idx_ff + SLOT_W'(1);
               end
            end
         end
         rht_pkg::S_COL_END: begin
            if (space) begin
               push.valid = 1'b1;
               push.last  = 1'b1;
               if (pend_ff) begin
                  push.handle = pend_handle_ff;
               end else begin
                  push.status = rht_pkg::STATUS_NONE;
               end
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rht_pkg::S_IDLE;
         valid_ff <= '0;
         idx_ff   <= '0;
         n_ff     <= '0;
         pend_ff  <= 1'b0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
         n_ff     <= n_in;
         pend_ff  <= pend_in;
         sat_ff   <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_handle_ff <= pend_handle_in;
      old_h_ff       <= old_h_in;
      new_h_ff       <= new_h_in;
   end

endmodule

// ----- rtl/refcount_handle_table.sv -----
// top level of the reference-counting handle table
//
//  channel   dir  beat contents                    accepted when
//  req_bus   in   command, old_handle, new_handle  req_bus.valid && req_bus.ready
//  rsp_bus   out  status, handle, last             rsp_bus.valid && rsp_bus.ready
//
// one command at a time; req_bus.ready is high only while the sequencer is idle
// allocate: one valid bit tested per cycle until a free slot, or the last slot answers full
// assign: old and new counts go one after the other through the count unit
// collect: each slot takes a memory read and a zero test
// a full output register stalls the sequencer; the table is empty after reset
module refcount_handle_table #(
   parameter int SLOTS = 16
) (
   input logic       clock,
   input logic       reset,
   rht_req_if.sink   req_bus,
   rht_rsp_if.source rsp_bus
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   rht_pkg::rsp_push_type push;
   rht_pkg::alu_op_type   alu_op;
   rht_pkg::alu_out_type  alu_res;
   rht_pkg::count_type    rd_data;
   rht_pkg::count_type    wr_data;
   logic [SLOT_W-1:0]     rd_addr;
   logic [SLOT_W-1:0]     wr_addr;
   logic                  wr_en;
   logic                  space;

   logic                  rsp_valid_ff, rsp_valid_in;
   rht_pkg::status_type   rsp_status_ff;
   rht_pkg::handle_type   rsp_handle_ff;
   logic                  rsp_last_ff;

   rht_count_ram #(
      .DEPTH (SLOTS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rht_alu u_alu (
      .op      (alu_op),
      .operand (rd_data),
      .res     (alu_res)
   );

   rht_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .space   (space),
      .push    (push),
      .alu_op  (alu_op),
      .alu_res (alu_res),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // output register takes a new beat when empty or being drained
   assign space = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         rsp_status_ff <= push.status;
         rsp_handle_ff <= push.handle;
         rsp_last_ff   <= push.last;
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.handle = rsp_handle_ff;
   assign rsp_bus.last   = rsp_last_ff;

endmodule

// ----- rtl/rht_checker.sv -----
// port-level checks on the handle table, bound to the top level
`include "refcount_handle_table_assert.svh"

module rht_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input rht_pkg::status_type rsp_status,
   input rht_pkg::handle_type rsp_handle,
   input logic                rsp_last
);

   logic [rht_pkg::STATUS_W+rht_pkg::HANDLE_W:0] rsp_beat;
   logic                                         rsp_stall;
   logic                                         rsp_none;
   logic                                         rsp_full;
   logic                                         rsp_empty_end;

   assign rsp_beat      = {rsp_status, rsp_handle, rsp_last};
   assign rsp_stall     = rsp_valid && !rsp_ready;
   assign rsp_none      = rsp_valid && (rsp_status == rht_pkg::STATUS_NONE);
   assign rsp_full      = rsp_valid && (rsp_status == rht_pkg::STATUS_FULL);
   assign rsp_empty_end = (rsp_handle == '0) && rsp_last;

   // a stalled result beat stays put
   `RHT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_beat))

   // nothing comes out straight after reset
   `RHT_ASSERT_ALW(a_rsp_reset, clock, reset, !rsp_valid)

   // an empty collect is a single closing beat with no handle
   `RHT_ASSERT_IMP(a_none_shape, clock, reset, rsp_none, rsp_empty_end)

   // a full table answers with one closing beat and no handle
   `RHT_ASSERT_IMP(a_full_shape, clock, reset, rsp_full, rsp_empty_end)

endmodule

bind refcount_handle_table rht_checker u_rht_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_status (rsp_bus.status),
   .rsp_handle (rsp_bus.handle),
   .rsp_last   (rsp_bus.last)
);

// ----- bench/refcount_handle_table_test.sv -----
// self-checking bench for the reference-counting handle table
module refcount_handle_table_test;
   import rht_pkg::*;

   localparam int           TABLE_SLOTS  = 16;
   localparam int           COUNT_TOP    = 255;
   localparam int           ITEM_TARGET  = 410;
   localparam int           TAIL_START   = 340;
   localparam int           SETTLE_WAIT  = 2 * TABLE_SLOTS + 8;
   localparam int           CYCLE_LIMIT  = 600000;
   localparam cmd_bits_type CMD_SPARE    = 2'd3;
   localparam handle_type   NULL_HANDLE  = '0;

   typedef struct packed {
      status_type status;
      handle_type handle;
      logic       last;
   } table_reply_t;

   // mirror of the handle table and the replies it owes
   class handle_table_scoreboard;
      bit           slot_live[TABLE_SLOTS];
      count_type    ref_total[TABLE_SLOTS];
      table_reply_t owed_replies[$];
      int           mismatches;
      int           commands_seen;
      int           replies_seen;
      int           freed_total;
      int           full_total;
      int           sat_total;
      int           none_total;

      function void clear_table();
         foreach (slot_live[i]) begin
            slot_live[i] = 1'b0;
            ref_total[i] = '0;
         end
      endfunction

      function int live_index(handle_type h);
         if (h == 0 || h > TABLE_SLOTS) return -1;
         if (!slot_live[h - 1]) return -1;
         return int'(h) - 1;
      endfunction

      function int free_slots();
         int n;
         n = 0;
         foreach (slot_live[i]) if (!slot_live[i]) n++;
         return n;
      endfunction

      function void owe(status_type s, handle_type h, logic l);
         table_reply_t r;
         r.status = s;
         r.handle = h;
         r.last   = l;
         owed_replies.push_back(r);
      endfunction

      function void note_command(cmd_bits_type cmd, handle_type old_h, handle_type new_h);
         int found;
         int os;
         int ns;
         int n;
         bit clamped;
         commands_seen++;
         case (cmd)
            CMD_ALLOC: begin
               found = -1;
               foreach (slot_live[i]) if (!slot_live[i] && found < 0) found = i;
               if (found < 0) begin
                  full_total++;
                  owe(STATUS_FULL, NULL_HANDLE, 1'b1);
               end else begin
                  slot_live[found] = 1'b1;
                  ref_total[found] = 8'd1;
                  owe(STATUS_OK, handle_type'(found + 1), 1'b1);
               end
            end
            CMD_ASSIGN: begin
               os = live_index(old_h);
               ns = live_index(new_h);
               clamped = 1'b0;
               // moving a reference onto the same entry changes nothing
               if (os >= 0 && os == ns) begin
                  owe(STATUS_OK, NULL_HANDLE, 1'b1);
               end else begin
                  if (os >= 0) begin
                     if (ref_total[os] == 0) clamped = 1'b1;
                     else ref_total[os] = ref_total[os] - 8'd1;
                  end
                  if (ns >= 0) begin
                     if (ref_total[ns] == COUNT_TOP) clamped = 1'b1;
                     else ref_total[ns] = ref_total[ns] + 8'd1;
                  end
                  if (clamped) sat_total++;
                  owe(clamped ? STATUS_SAT : STATUS_OK, NULL_HANDLE, 1'b1);
               end
            end
            CMD_COLLECT: begin
               n = 0;
               for (int i = 0; i < TABLE_SLOTS && n < MAX_RESULTS; i++) begin
                  if (slot_live[i] && ref_total[i] == 0) begin
                     slot_live[i] = 1'b0;
                     owe(STATUS_OK, handle_type'(i + 1), 1'b0);
                     n++;
                  end
               end
               if (n == 0) begin
                  none_total++;
                  owe(STATUS_NONE, NULL_HANDLE, 1'b1);
               end else begin
                  owed_replies[owed_replies.size() - 1].last = 1'b1;
                  freed_total += n;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_reply(status_type s, handle_type h, logic l);
         table_reply_t want;
         replies_seen++;
         if (owed_replies.size() == 0) begin
            $error("unexpected response beat: status %0d handle %0d last %0d", s, h, l);
            mismatches++;
            return;
         end
         want = owed_replies.pop_front();
         if (s !== want.status) begin
            $error("status mismatch: expected %0d actual %0d", want.status, s);
            mismatches++;
         end
         if (h !== want.handle) begin
            $error("handle mismatch: expected %0d actual %0d", want.handle, h);
            mismatches++;
         end
         if (l !== want.last) begin
            $error("last mismatch: expected %0d actual %0d", want.last, l);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   rht_req_if req_bus ();
   rht_rsp_if rsp_bus ();

   refcount_handle_table #(.SLOTS(TABLE_SLOTS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   handle_table_scoreboard table_sb;
   int                     counted_items;
   int                     gap_percent;
   bit                     quiet_tail;
   bit                     pumped;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timed out after %0d cycles", CYCLE_LIMIT);
      $display("refcount_handle_table test failed");
      $finish;
   end

   // response side: ready stretches broken by stall bursts
   initial begin
      forever begin
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 60)) @(posedge clock);
         if (!quiet_tail) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         table_sb.check_reply(rsp_bus.status, rsp_bus.handle, rsp_bus.last);
   end

   // one request beat; valid stays high for the next beat unless a gap follows
   task automatic issue(input cmd_bits_type cmd, input handle_type old_h,
                        input handle_type new_h);
      if (!quiet_tail && $urandom_range(0, 99) < gap_percent) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.old_handle <= old_h;
      req_bus.new_handle <= new_h;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      table_sb.note_command(cmd, old_h, new_h);
      if (cmd != CMD_SPARE) counted_items++;
   endtask

   function automatic handle_type pick_live();
      handle_type picks[$];
      for (int i = 0; i < TABLE_SLOTS; i++)
         if (table_sb.slot_live[i]) picks.push_back(handle_type'(i + 1));
      if (picks.size() == 0) return NULL_HANDLE;
      return picks[$urandom_range(0, picks.size() - 1)];
   endfunction

   // mostly live handles, some null, some out of range or freed
   function automatic handle_type mixed_handle();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return pick_live();
      if (roll < 75) return NULL_HANDLE;
      return handle_type'($urandom_range(0, 31));
   endfunction

   // a handle that can never gain a reference
   function automatic handle_type dead_handle();
      if ($urandom_range(0, 1) == 0) return NULL_HANDLE;
      return handle_type'($urandom_range(TABLE_SLOTS + 1, 31));
   endfunction

   task automatic churn(input int beats);
      int roll;
      repeat (beats) begin
         roll = $urandom_range(0, 99);
         if (roll < 20) issue(CMD_ALLOC, dead_handle(), mixed_handle());
         else if (roll < 70) issue(CMD_ASSIGN, mixed_handle(), mixed_handle());
         else if (roll < 82) issue(CMD_COLLECT, mixed_handle(), mixed_handle());
         else if (roll < 92)
            issue(CMD_ASSIGN, handle_type'($urandom_range(0, 31)),
                  handle_type'($urandom_range(0, 31)));
         else
            issue(CMD_SPARE, handle_type'($urandom_range(0, 31)),
                  handle_type'($urandom_range(0, 31)));
      end
   endtask

   // bring a few lightly used entries down to zero, then sweep them
   task automatic drain_and_collect();
      handle_type h;
      handle_type dst;
      int         picks;
      picks = $urandom_range(1, TABLE_SLOTS);
      repeat (picks) begin
         h = pick_live();
         if (h != 0 && table_sb.ref_total[h - 1] <= 8) begin
            while (table_sb.slot_live[h - 1] && table_sb.ref_total[h - 1] != 0) begin
               dst = ($urandom_range(0, 4) == 0) ? pick_live() : dead_handle();
               issue(CMD_ASSIGN, h, dst);
            end
            // now and then push below zero
            if ($urandom_range(0, 3) == 0) issue(CMD_ASSIGN, h, dead_handle());
         end
      end
      issue(CMD_COLLECT, mixed_handle(), mixed_handle());
   endtask

   task automatic fill_table();
      while (table_sb.free_slots() != 0) issue(CMD_ALLOC, mixed_handle(), mixed_handle());
      issue(CMD_ALLOC, mixed_handle(), mixed_handle());
   endtask

   // drive one entry up to the count ceiling and a little past it
   task automatic pump_to_ceiling();
      handle_type h;
      handle_type src;
      int         extra;
      int         roll;
      h = pick_live();
      if (h == 0) begin
         issue(CMD_ALLOC, NULL_HANDLE, NULL_HANDLE);
         h = pick_live();
      end
      extra = 0;
      while (extra < 3) begin
         roll = $urandom_range(0, 9);
         if (roll < 6) src = dead_handle();
         else if (roll < 7) src = h;
         else src = pick_live();
         if (table_sb.ref_total[h - 1] == COUNT_TOP) extra++;
         issue(CMD_ASSIGN, src, h);
      end
      pumped = 1'b1;
   endtask

   initial begin
      table_sb = new();
      table_sb.clear_table();
      counted_items = 0;
      gap_percent   = 0;
      quiet_tail    = 1'b0;
      pumped        = 1'b0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.command    <= CMD_ALLOC;
      req_bus.old_handle <= NULL_HANDLE;
      req_bus.new_handle <= NULL_HANDLE;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty sweep, null moves, full table, the underflow clamp, bad handles
      issue(CMD_COLLECT, NULL_HANDLE, NULL_HANDLE);
      issue(CMD_ASSIGN, NULL_HANDLE, NULL_HANDLE);
      repeat (TABLE_SLOTS) issue(CMD_ALLOC, NULL_HANDLE, NULL_HANDLE);
      issue(CMD_ALLOC, 5'd31, 5'd31);
      issue(CMD_ASSIGN, 5'd1, 5'd1);
      issue(CMD_ASSIGN, 5'd1, handle_type'(TABLE_SLOTS));
      issue(CMD_ASSIGN, 5'd1, 5'd31);
      issue(CMD_ASSIGN, handle_type'(TABLE_SLOTS + 1), NULL_HANDLE);
      issue(CMD_SPARE, 5'd31, 5'd31);
      issue(CMD_COLLECT, 5'd31, 5'd31);

      while (counted_items < ITEM_TARGET) begin
         case ($urandom_range(0, 3))
            0: gap_percent = 0;
            1: gap_percent = 10;
            2: gap_percent = 30;
            default: gap_percent = 60;
         endcase
         if (counted_items >= TAIL_START) quiet_tail = 1'b1;
         if (!pumped && counted_items > 100) pump_to_ceiling();
         else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: churn($urandom_range(4, 16));
               4, 5, 6:    drain_and_collect();
               7:          fill_table();
               8:          if (!pumped && counted_items > 40) pump_to_ceiling();
                           else churn($urandom_range(4, 16));
               default:    issue(CMD_COLLECT, mixed_handle(), mixed_handle());
            endcase
         end
      end
      req_bus.valid <= 1'b0;

      while (table_sb.owed_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);

      $display("%0d commands and %0d response beats checked", table_sb.commands_seen,
               table_sb.replies_seen);
      $display("%0d handles freed, %0d full-table refusals, %0d clamped counts, %0d empty sweeps",
               table_sb.freed_total, table_sb.full_total, table_sb.sat_total,
               table_sb.none_total);
      if (table_sb.mismatches == 0 && table_sb.owed_replies.size() == 0) begin
         $display("refcount_handle_table test passed");
      end else begin
         $display("refcount_handle_table test failed");
      end
      $finish;
   end

endmodule
